### sv/ldnw_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// ldnw_pkg
// Shared types and constants for the decimal number writer.
// ---------------------------------------------------------------------------
package ldnw_pkg;

   localparam int unsigned VALUE_W     = 32;
   localparam int unsigned COLUMN_W    = 6;
   localparam int unsigned ADDR_W      = 7;
   localparam int unsigned DIGIT_W     = 4;
   localparam int unsigned BYTE_W      = 8;
   localparam int unsigned NIBBLE_W    = 4;
   localparam int unsigned REQ_DATA_W  = 40;

   // reciprocal of ten, exact floor for any 32-bit dividend
   localparam logic [VALUE_W-1:0] RECIP_TEN  = 32'hCCCC_CCCD;
   localparam int unsigned        RECIP_SHIFT = 35;

   localparam logic [BYTE_W-1:0] CMD_SET_ADDR = 8'h80;
   localparam logic [BYTE_W-1:0] ASCII_ZERO   = 8'h30;

   localparam logic RS_INSTR = 1'b0;
   localparam logic RS_DATA  = 1'b1;

   localparam logic MODE_FOUR_BIT  = 1'b0;
   localparam logic MODE_EIGHT_BIT = 1'b1;

   typedef struct packed {
      logic [VALUE_W-1:0] quotient;
      logic [DIGIT_W-1:0] remainder;
   } div_result_type;

   typedef enum logic [3:0] {
      ST_IDLE   = 4'b0001,
      ST_DIVIDE = 4'b0010,
      ST_STORE  = 4'b0100,
      ST_EMIT   = 4'b1000
   } state_type;

endpackage
`default_nettype wire

### sv/ldnw_div10.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// ldnw_div10
// Divide-by-ten unit: registered reciprocal multiply, then remainder fixup.
// ---------------------------------------------------------------------------
module ldnw_div10 (
   input  wire                                clock,
   input  wire                                load,
   input  wire  [ldnw_pkg::VALUE_W-1:0]       dividend,
   output ldnw_pkg::div_result_type           result
);

   logic [2*ldnw_pkg::VALUE_W-1:0] product_ff;
   logic [2*ldnw_pkg::VALUE_W-1:0] product_in;
   logic [ldnw_pkg::VALUE_W-1:0]   dividend_ff;
   logic [ldnw_pkg::VALUE_W-1:0]   dividend_in;
   logic [ldnw_pkg::VALUE_W-1:0]   quotient;
   logic [ldnw_pkg::VALUE_W-1:0]   times_ten;
   logic [ldnw_pkg::VALUE_W-1:0]   diff;

   always_comb begin
      product_in  = product_ff;
      dividend_in = dividend_ff;
      if (load) begin
         product_in  = {{ldnw_pkg::VALUE_W{1'b0}}, dividend} *
                       {{ldnw_pkg::VALUE_W{1'b0}}, ldnw_pkg::RECIP_TEN};
         dividend_in = dividend;
      end
   end

   always_ff @(posedge clock) begin
      product_ff  <= product_in;
      dividend_ff <= dividend_in;
   end

   always_comb begin
      quotient  = ldnw_pkg::VALUE_W'(product_ff >> ldnw_pkg::RECIP_SHIFT);
      times_ten = (quotient << 3) + (quotient << 1);
      diff      = dividend_ff - times_ten;
      result.quotient  = quotient;
      result.remainder = diff[ldnw_pkg::DIGIT_W-1:0];
   end

endmodule
`default_nettype wire

### sv/lcd_decimal_number_writer.sv
// Conversion: one digit at a time through the divide and store states using the
//   shared divide-by-ten unit, then one word per cycle out through the single
//   output register while the receiver is ready, 2 words per digit in eight-bit
//   mode and 4 in four-bit mode. A new number waits until the last word is issued.
// Reset: synchronous, active high; clears the sequencer, counters, the
//   output valid and bus_mode (four-bit). Digit storage is not cleared.
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// lcd_decimal_number_writer
// Converts a 32-bit value to decimal digits and emits set-address / data
// transfers for a character display, in four-bit or eight-bit bus mode.
// ---------------------------------------------------------------------------
module lcd_decimal_number_writer #(
   parameter int unsigned MAX_DIGITS = 10
) (
   input  wire         clock,
   input  wire         reset,
   // configuration
   input  wire         csr_valid,
   output logic        csr_ready,
   input  wire  [0:0]  csr_data,      // bus_mode
   // request
   input  wire         req_tvalid,
   output logic        req_tready,
   input  wire  [39:0] req_tdata,     // value[31:0], line[32], column[38:33], pad
   // response
   output logic        rsp_tvalid,
   input  wire         rsp_tready,
   output logic [7:0]  rsp_tdata,     // bus_value[7:0]
   output logic        rsp_tuser,     // reg_select
   output logic        rsp_tlast
);

   localparam int unsigned CNT_W = $clog2(MAX_DIGITS + 1);
   localparam int unsigned IDX_W = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;

   ldnw_pkg::state_type state_ff, state_in;

   logic                              bus_mode_ff, bus_mode_in;
   logic [ldnw_pkg::VALUE_W-1:0]      value_ff, value_in;
   logic                              line_ff, line_in;
   logic [ldnw_pkg::COLUMN_W-1:0]     column_ff, column_in;
   logic [CNT_W-1:0]                  digit_count_ff, digit_count_in;
   logic [CNT_W-1:0]                  digit_index_ff, digit_index_in;
   logic                              byte_sel_ff, byte_sel_in;
   logic                              nibble_ff, nibble_in;
   logic [ldnw_pkg::DIGIT_W-1:0]      digit_store_ff [MAX_DIGITS];

   logic                              rsp_valid_ff, rsp_valid_in;
   logic [ldnw_pkg::BYTE_W-1:0]       rsp_data_ff, rsp_data_in;
   logic                              rsp_user_ff, rsp_user_in;
   logic                              rsp_last_ff, rsp_last_in;

   ldnw_pkg::div_result_type          div_result;
   logic                              div_load;
   logic                              store_en;
   logic                              req_accept;
   logic                              out_free;
   logic [CNT_W-1:0]                  count_next;
   logic [CNT_W-1:0]                  read_pos;
   logic [ldnw_pkg::DIGIT_W-1:0]      read_digit;
   logic [ldnw_pkg::ADDR_W-1:0]       ddram_addr;
   logic [ldnw_pkg::BYTE_W-1:0]       cur_byte;
   logic [ldnw_pkg::BYTE_W-1:0]       cur_word;
   logic                              byte_done;
   logic                              final_word;

   ldnw_div10 u_div10 (
      .clock    (clock),
      .load     (div_load),
      .dividend (value_ff),
      .result   (div_result)
   );

   assign csr_ready  = 1'b1;
   assign req_tready = (state_ff == ldnw_pkg::ST_IDLE);
   assign req_accept = req_tvalid & req_tready;
   assign out_free   = ~rsp_valid_ff | rsp_tready;
   assign div_load   = (state_ff == ldnw_pkg::ST_DIVIDE);
   assign store_en   = (state_ff == ldnw_pkg::ST_STORE);
   assign count_next = digit_count_ff + CNT_W'(1);

   // digit fetch, most significant first
   assign read_pos   = digit_count_ff - CNT_W'(1) - digit_index_ff;
   assign read_digit = digit_store_ff[read_pos[IDX_W-1:0]];

   always_comb begin
      ddram_addr = {line_ff, {ldnw_pkg::COLUMN_W{1'b0}}}
                 + {1'b0, column_ff}
                 + ldnw_pkg::ADDR_W'(digit_index_ff);
      cur_byte = byte_sel_ff
               ? (ldnw_pkg::ASCII_ZERO + {4'b0000, read_digit})
               : (ldnw_pkg::CMD_SET_ADDR | {1'b0, ddram_addr});
      if (bus_mode_ff == ldnw_pkg::MODE_EIGHT_BIT) begin
         cur_word = cur_byte;
      end else if (nibble_ff) begin
         cur_word = {4'b0000, cur_byte[3:0]};
      end else begin
         cur_word = {4'b0000, cur_byte[7:4]};
      end
      byte_done  = (bus_mode_ff == ldnw_pkg::MODE_EIGHT_BIT) | nibble_ff;
      final_word = byte_done & byte_sel_ff & (digit_index_ff == digit_count_ff - CNT_W'(1));
   end

   always_comb begin
      state_in       = state_ff;
      bus_mode_in    = bus_mode_ff;
      value_in       = value_ff;
      line_in        = line_ff;
      column_in      = column_ff;
      digit_count_in = digit_count_ff;
      digit_index_in = digit_index_ff;
      byte_sel_in    = byte_sel_ff;
      nibble_in      = nibble_ff;
      rsp_valid_in   = rsp_valid_ff & ~rsp_tready;
      rsp_data_in    = rsp_data_ff;
      rsp_user_in    = rsp_user_ff;
      rsp_last_in    = rsp_last_ff;

      if (csr_valid & csr_ready) begin
         bus_mode_in = csr_data[0];
      end

      unique case (state_ff)
         ldnw_pkg::ST_IDLE: begin
            if (req_accept) begin
               value_in       = req_tdata[31:0];
               line_in        = req_tdata[32];
               column_in      = req_tdata[38:33];
               digit_count_in = '0;
               state_in       = ldnw_pkg::ST_DIVIDE;
            end
         end
         ldnw_pkg::ST_DIVIDE: begin
            state_in = ldnw_pkg::ST_STORE;
         end
         ldnw_pkg::ST_STORE: begin
            value_in       = div_result.quotient;
            digit_count_in = count_next;
            if ((div_result.quotient == '0) || (count_next == CNT_W'(MAX_DIGITS))) begin
               digit_index_in = '0;
               byte_sel_in    = 1'b0;
               nibble_in      = 1'b0;
               state_in       = ldnw_pkg::ST_EMIT;
            end else begin
               state_in = ldnw_pkg::ST_DIVIDE;
            end
         end
         ldnw_pkg::ST_EMIT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = cur_word;
               rsp_user_in  = byte_sel_ff ? ldnw_pkg::RS_DATA : ldnw_pkg::RS_INSTR;
               rsp_last_in  = final_word;
               if (byte_done) begin
                  nibble_in = 1'b0;
                  if (byte_sel_ff) begin
                     byte_sel_in    = 1'b0;
                     digit_index_in = digit_index_ff + CNT_W'(1);
                  end else begin
                     byte_sel_in = 1'b1;
                  end
               end else begin
                  nibble_in = 1'b1;
               end
               if (final_word) begin
                  state_in = ldnw_pkg::ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ldnw_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ldnw_pkg::ST_IDLE;
         bus_mode_ff    <= ldnw_pkg::MODE_FOUR_BIT;
         digit_count_ff <= '0;
         digit_index_ff <= '0;
         byte_sel_ff    <= 1'b0;
         nibble_ff      <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         bus_mode_ff    <= bus_mode_in;
         digit_count_ff <= digit_count_in;
         digit_index_ff <= digit_index_in;
         byte_sel_ff    <= byte_sel_in;
         nibble_ff      <= nibble_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      value_ff    <= value_in;
      line_ff     <= line_in;
      column_ff   <= column_in;
      rsp_data_ff <= rsp_data_in;
      rsp_user_ff <= rsp_user_in;
      rsp_last_ff <= rsp_last_in;
      if (store_en) begin
         digit_store_ff[digit_count_ff[IDX_W-1:0]] <= div_result.remainder;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;
   assign rsp_tlast  = rsp_last_ff;

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      digit_count_ff <= CNT_W'(MAX_DIGITS))
      else $error("digit count past limit");

   a_emit_index: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ldnw_pkg::ST_EMIT) |-> (digit_index_ff < digit_count_ff))
      else $error("digit index past digit count");

   a_rem_digit: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ldnw_pkg::ST_STORE) |-> (div_result.remainder < 4'd10))
      else $error("remainder not a decimal digit");

   a_last_is_data: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_last_ff) |-> (rsp_user_ff == ldnw_pkg::RS_DATA))
      else $error("final word is not a data transfer");

   a_nibble_clean: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (bus_mode_ff == ldnw_pkg::MODE_FOUR_BIT)) |-> (rsp_data_ff[7:4] == 4'h0))
      else $error("upper nibble set in four-bit mode");

endmodule
`default_nettype wire

### tb/sv/tb_lcd_decimal_number_writer.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_lcd_decimal_number_writer
// Self-checking bench for the decimal number writer. Numbers with a row and
// a start column go in on the request stream. A behavioral model, or a known
// word list for some directed rows, gives the set-address and digit words for
// the current bus mode, and every response word is checked against them in
// order. A short directed table is followed by random numbers in several bus-mode
// phases. Both stream sides pause in random bursts, except in the final phase.
// ---------------------------------------------------------------------------
module tb_lcd_decimal_number_writer;

   localparam int NUM_DIGITS     = 10;
   localparam int MAX_WORDS      = 40;
   localparam int NUM_PHASES     = 6;
   localparam int PHASE_ITEMS    = 30;
   localparam int DRAIN_CYCLES   = 60;
   localparam int CYCLE_LIMIT    = 400000;
   localparam int REPORT_LIMIT   = 10;

   typedef struct packed {
      logic       rs;
      logic [7:0] bus;
      logic       last;
   } lcd_word_type;

   // known: up to four words of {reg_select, byte}, word i at [9*i +: 9]
   typedef struct packed {
      logic [31:0] num;
      logic        row;
      logic [5:0]  column;
      logic        mode;
      logic [2:0]  n_known;
      logic [35:0] known;
   } stim_row_type;

   localparam int NUM_ROWS = 18;
   localparam stim_row_type DIRECTED_ROWS [0:NUM_ROWS-1] = '{
      '{32'd0,          1'b0, 6'd0,  ldnw_pkg::MODE_FOUR_BIT,  3'd4,
        {9'h100, 9'h103, 9'h000, 9'h008}},
      '{32'd9,          1'b1, 6'd0,  ldnw_pkg::MODE_FOUR_BIT,  3'd4,
        {9'h109, 9'h103, 9'h000, 9'h00C}},
      '{32'hFFFF_FFFF,  1'b1, 6'd39, ldnw_pkg::MODE_FOUR_BIT,  3'd0, 36'h0},
      '{32'd1000000000, 1'b0, 6'd0,  ldnw_pkg::MODE_FOUR_BIT,  3'd0, 36'h0},
      '{32'd10,         1'b0, 6'd39, ldnw_pkg::MODE_FOUR_BIT,  3'd0, 36'h0},
      '{32'd12345,      1'b1, 6'd63, ldnw_pkg::MODE_FOUR_BIT,  3'd0, 36'h0},
      '{32'd7,          1'b0, 6'd63, ldnw_pkg::MODE_FOUR_BIT,  3'd4,
        {9'h107, 9'h103, 9'h00F, 9'h00B}},
      '{32'h8000_0000,  1'b0, 6'd20, ldnw_pkg::MODE_FOUR_BIT,  3'd0, 36'h0},
      '{32'd99,         1'b1, 6'd38, ldnw_pkg::MODE_FOUR_BIT,  3'd0, 36'h0},
      '{32'd100,        1'b0, 6'd1,  ldnw_pkg::MODE_FOUR_BIT,  3'd0, 36'h0},
      '{32'd0,          1'b0, 6'd0,  ldnw_pkg::MODE_EIGHT_BIT, 3'd2,
        {18'h0, 9'h130, 9'h080}},
      '{32'd5,          1'b1, 6'd39, ldnw_pkg::MODE_EIGHT_BIT, 3'd2,
        {18'h0, 9'h135, 9'h0E7}},
      '{32'hFFFF_FFFF,  1'b0, 6'd0,  ldnw_pkg::MODE_EIGHT_BIT, 3'd0, 36'h0},
      '{32'hFFFF_FFFF,  1'b1, 6'd63, ldnw_pkg::MODE_EIGHT_BIT, 3'd0, 36'h0},
      '{32'd1,          1'b1, 6'd63, ldnw_pkg::MODE_EIGHT_BIT, 3'd2,
        {18'h0, 9'h131, 9'h0FF}},
      '{32'd1234567890, 1'b0, 6'd5,  ldnw_pkg::MODE_EIGHT_BIT, 3'd0, 36'h0},
      '{32'd999999999,  1'b1, 6'd31, ldnw_pkg::MODE_EIGHT_BIT, 3'd0, 36'h0},
      '{32'd10,         1'b0, 6'd0,  ldnw_pkg::MODE_EIGHT_BIT, 3'd0, 36'h0}
   };

   logic        clock;
   logic        reset;
   logic        csr_valid;
   logic        csr_ready;
   logic [0:0]  csr_data;
   logic        req_tvalid;
   logic        req_tready;
   logic [39:0] req_tdata;     // value[31:0], line[32], column[38:33], pad
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [7:0]  rsp_tdata;     // bus_value[7:0]
   logic        rsp_tuser;     // reg_select
   logic        rsp_tlast;

   lcd_word_type pending_words[$];
   logic         lcd_mode;
   logic         quiet;
   int           errors;
   int           cycle_count;

   lcd_decimal_number_writer uut (
      .clock      (clock),
      .reset      (reset),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   initial begin
      reset       = 1'b1;
      csr_valid   = 1'b0;
      csr_data    = 1'b0;
      req_tvalid  = 1'b0;
      req_tdata   = '0;
      rsp_tready  = 1'b0;
      lcd_mode    = ldnw_pkg::MODE_FOUR_BIT;
      quiet       = 1'b0;
      errors      = 0;
      cycle_count = 0;
   end

   // set-address and digit words for one number, in the current bus mode
   task automatic predict_lcd_words(input logic [31:0] num, input logic row,
                                    input logic [5:0] column);
      logic [3:0]   digits [NUM_DIGITS];
      lcd_word_type words [MAX_WORDS];
      logic [31:0]  rest;
      logic [6:0]   addr;
      logic [7:0]   byte_out;
      logic         rs;
      int           cnt;
      int           n;
      rest = num;
      cnt  = 0;
      n    = 0;
      do begin
         digits[cnt] = 4'(rest % 10);
         rest = rest / 10;
         cnt++;
      end while (rest != 0 && cnt < NUM_DIGITS);
      for (int k = 0; k < cnt; k++) begin
         addr = 7'((int'(row) * 64 + int'(column) + k) & 8'h7F);
         for (int b = 0; b < 2; b++) begin
            byte_out = (b == 0) ? (ldnw_pkg::CMD_SET_ADDR | {1'b0, addr})
                                : (ldnw_pkg::ASCII_ZERO + {4'h0, digits[cnt - 1 - k]});
            rs = (b == 0) ? ldnw_pkg::RS_INSTR : ldnw_pkg::RS_DATA;
            if (lcd_mode == ldnw_pkg::MODE_EIGHT_BIT) begin
               words[n] = '{rs: rs, bus: byte_out, last: 1'b0};
               n++;
            end else begin
               words[n] = '{rs: rs, bus: {4'h0, byte_out[7:4]}, last: 1'b0};
               words[n + 1] = '{rs: rs, bus: {4'h0, byte_out[3:0]}, last: 1'b0};
               n += 2;
            end
         end
      end
      words[n - 1].last = 1'b1;
      for (int i = 0; i < n; i++)
         pending_words.push_back(words[i]);
   endtask

   task automatic flag_mismatch(input string what, input int want, input int got);
      errors++;
      if (errors <= REPORT_LIMIT)
         $display("%0t: %s mismatch: expected 0x%0h, got 0x%0h", $realtime, what,
                  want, got);
   endtask

   // one number on the request stream; expectations are queued on acceptance
   task automatic put_number(input logic [31:0] num, input logic row,
                             input logic [5:0] column, input logic [2:0] n_known,
                             input logic [35:0] known);
      int gap;
      lcd_word_type w;
      if (!quiet && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 5);
         @(negedge clock);
         req_tvalid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tdata  <= {1'b0, column, row, num};
      do @(posedge clock); while (!req_tready);
      if (n_known == 0) begin
         predict_lcd_words(num, row, column);
      end else begin
         for (int i = 0; i < n_known; i++) begin
            w.rs   = known[9 * i + 8];
            w.bus  = known[9 * i +: 8];
            w.last = (i == n_known - 1);
            pending_words.push_back(w);
         end
      end
   endtask

   // stop sending and wait for every queued word to come back
   task automatic drain_words;
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (pending_words.size() != 0) @(posedge clock);
   endtask

   task automatic set_bus_mode(input logic mode);
      drain_words();
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_data  <= mode;
      do @(posedge clock); while (!csr_ready);
      lcd_mode = mode;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // receiver: random stall bursts, none once quiet
   initial begin
      int stall_left;
      stall_left = 0;
      forever begin
         @(negedge clock);
         if (!quiet && stall_left == 0 && $urandom_range(0, 5) == 0)
            stall_left = $urandom_range(1, 5);
         if (stall_left > 0) begin
            rsp_tready <= 1'b0;
            stall_left--;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      lcd_word_type w;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_words.size() == 0) begin
            errors++;
            if (errors <= REPORT_LIMIT)
               $display("%0t: unexpected word rs=%0b data=0x%0h last=%0b", $realtime,
                        rsp_tuser, rsp_tdata, rsp_tlast);
         end else begin
            w = pending_words.pop_front();
            if (rsp_tuser !== w.rs)
               flag_mismatch("reg_select", w.rs, rsp_tuser);
            if (rsp_tdata !== w.bus)
               flag_mismatch("bus_value", w.bus, rsp_tdata);
            if (rsp_tlast !== w.last)
               flag_mismatch("last", w.last, rsp_tlast);
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   initial begin
      logic [31:0] num;
      logic [31:0] pow;
      logic [5:0]  column;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      set_bus_mode(ldnw_pkg::MODE_FOUR_BIT);
      for (int i = 0; i < NUM_ROWS; i++) begin
         if (DIRECTED_ROWS[i].mode != lcd_mode)
            set_bus_mode(DIRECTED_ROWS[i].mode);
         put_number(DIRECTED_ROWS[i].num, DIRECTED_ROWS[i].row,
                    DIRECTED_ROWS[i].column, DIRECTED_ROWS[i].n_known,
                    DIRECTED_ROWS[i].known);
      end

      for (int ph = 0; ph < NUM_PHASES; ph++) begin
         set_bus_mode((ph % 2 == 0) ? ldnw_pkg::MODE_FOUR_BIT : ldnw_pkg::MODE_EIGHT_BIT);
         quiet = (ph == NUM_PHASES - 1);
         for (int i = 0; i < PHASE_ITEMS; i++) begin
            case ($urandom_range(0, 5))
               0: num = $urandom_range(0, 9);
               1: num = $urandom_range(0, 99999);
               2: num = $urandom;
               3: begin
                  pow = 1;
                  repeat ($urandom_range(0, 9)) pow = pow * 10;
                  num = pow - $urandom_range(0, 1);
               end
               4: num = 32'hFFFF_FFFF - $urandom_range(0, 3);
               default: num = $urandom >> $urandom_range(0, 31);
            endcase
            column = ($urandom_range(0, 3) == 0) ? 6'($urandom_range(0, 63))
                                                 : 6'($urandom_range(0, 39));
            put_number(num, 1'($urandom_range(0, 1)), column, 3'd0, 36'h0);
            if (ph == 2 && i == PHASE_ITEMS / 2)
               drain_words();
         end
      end

      drain_words();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (errors == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule
